### src/ws2812_spi_frame_encoder_rainbow_macros.svh
// Assertion macros shared by the frame encoder RTL.
`ifndef WS2812_SPI_FRAME_ENCODER_RAINBOW_MACROS_SVH
`define WS2812_SPI_FRAME_ENCODER_RAINBOW_MACROS_SVH

// Property checked at every clock edge outside reset.
`define WSENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WSENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/wsenc_pkg.sv
// Shared constants, codes and control/status types of the frame encoder.
package wsenc_pkg;

  localparam int LED_COUNT = 64;
  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int DATA_LEN  = LED_COUNT * 24;
  localparam int POS_W     = $clog2(DATA_LEN + 256);
  localparam int BIT_W     = 5;
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(23);

  // action codes
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RAINBOW = 2'd1;
  localparam logic [1:0] ACT_BYTE    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ZERO_PAT = 3'd0;
  localparam logic [2:0] REG_ONE_PAT  = 3'd1;
  localparam logic [2:0] REG_LATCH    = 3'd2;
  localparam logic [2:0] REG_MAX_LVL  = 3'd3;
  localparam logic [2:0] REG_STEP_LVL = 3'd4;

  // register reset values
  localparam logic [7:0] RST_ZERO_PAT = 8'hE0;
  localparam logic [7:0] RST_ONE_PAT  = 8'hF8;
  localparam logic [7:0] RST_LATCH    = 8'd192;
  localparam logic [7:0] RST_MAX_LVL  = 8'd63;
  localparam logic [7:0] RST_STEP_LVL = 8'd1;

  typedef struct packed {
    logic wr_item;     // store a color write
    logic rd_led0;     // read address forced to LED 0
    logic frame_norm;  // restart frame if position ran past its end
    logic rb_load;     // load walking color from read data
    logic rb_step;     // one hue step, store to walk index
    logic out_load;    // load output register, advance frame position
  } cmd_t;

  typedef struct packed {
    logic out_block;   // output register full and stalled
    logic walk_done;   // walk index at last LED
  } sts_t;

endpackage

### src/wsenc_ctrl.sv
// Controller state machine of the frame encoder.
module wsenc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  wsenc_pkg::sts_t   sts,
  output wsenc_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RB_LOAD = 2'd1;
  localparam logic [1:0] ST_RB_WALK = 2'd2;
  localparam logic [1:0] ST_BYTE    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            wsenc_pkg::ACT_WRITE: begin
              cmd.wr_item = 1'b1;
            end
            wsenc_pkg::ACT_RAINBOW: begin
              cmd.rd_led0 = 1'b1;
              state_next  = ST_RB_LOAD;
            end
            wsenc_pkg::ACT_BYTE: begin
              cmd.frame_norm = 1'b1;
              state_next     = ST_BYTE;
            end
            default: ;
          endcase
        end
      end
      ST_RB_LOAD: begin
        cmd.rb_load = 1'b1;
        state_next  = ST_RB_WALK;
      end
      ST_RB_WALK: begin
        cmd.rb_step = 1'b1;
        if (sts.walk_done) state_next = ST_IDLE;
      end
      ST_BYTE: begin
        if (!sts.out_block) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

### src/wsenc_dp.sv
// Datapath of the frame encoder: registers, color store, frame counters, hue walk.
`include "ws2812_spi_frame_encoder_rainbow_macros.svh"

module wsenc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  wsenc_pkg::cmd_t      cmd,
  output wsenc_pkg::sts_t      sts,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [5:0]           led_sel,
  input  logic [23:0]          color,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 frame_last
);

  localparam int LW = wsenc_pkg::LED_W;
  localparam int PW = wsenc_pkg::POS_W;
  localparam int BW = wsenc_pkg::BIT_W;

  // configuration
  logic [7:0] zero_pat, one_pat, latch_len, max_lvl, step_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pat  <= wsenc_pkg::RST_ZERO_PAT;
      one_pat   <= wsenc_pkg::RST_ONE_PAT;
      latch_len <= wsenc_pkg::RST_LATCH;
      max_lvl   <= wsenc_pkg::RST_MAX_LVL;
      step_lvl  <= wsenc_pkg::RST_STEP_LVL;
    end else if (cfg_we) begin
      case (cfg_index)
        wsenc_pkg::REG_ZERO_PAT: zero_pat  <= cfg_data;
        wsenc_pkg::REG_ONE_PAT:  one_pat   <= cfg_data;
        wsenc_pkg::REG_LATCH:    latch_len <= cfg_data;
        wsenc_pkg::REG_MAX_LVL:  max_lvl   <= cfg_data;
        wsenc_pkg::REG_STEP_LVL: step_lvl  <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position, kept alongside its LED / bit split
  logic [PW-1:0] pos;
  logic [LW-1:0] led;
  logic [BW-1:0] bitn;
  logic [PW-1:0] len;
  logic [PW-1:0] pos_inc;
  logic          pos_over;
  logic          in_data;
  logic [LW-1:0] led_eff;

  assign len      = PW'(wsenc_pkg::DATA_LEN) + PW'(latch_len);
  assign pos_over = (pos >= len);
  assign in_data  = (pos < PW'(wsenc_pkg::DATA_LEN));
  assign led_eff  = (pos_over || !in_data) ? '0 : led;
  assign pos_inc  = pos + PW'(1);

  // color store, entries read as black until written
  logic [23:0]          mem [wsenc_pkg::LED_COUNT];
  logic [wsenc_pkg::LED_COUNT-1:0] vld;
  logic [LW-1:0]        rd_addr;
  logic [23:0]          rd_data;
  logic                 rd_vld;
  logic [23:0]          rd_color;
  logic                 wr_en;
  logic [LW-1:0]        wr_addr;
  logic [23:0]          wr_data;
  logic                 item_in_range;

  // walk state
  logic [23:0]   walk;
  logic [23:0]   walk_next;
  logic [LW-1:0] widx;

  assign rd_addr       = cmd.rd_led0 ? '0 : led_eff;
  assign rd_color      = rd_vld ? rd_data : 24'd0;
  assign item_in_range = ({26'd0, led_sel} < 32'(wsenc_pkg::LED_COUNT));
  assign wr_en         = (cmd.wr_item && item_in_range) || cmd.rb_step;
  assign wr_addr       = cmd.rb_step ? widx : LW'(led_sel);
  assign wr_data       = cmd.rb_step ? walk_next : color;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      rd_vld <= vld[rd_addr];
    end
  end

  // one step of the hue walk
  function automatic logic [23:0] hue_step(input logic [23:0] c,
                                           input logic [7:0] mx,
                                           input logic [7:0] st);
    logic [7:0] g, r, b;
    g = c[23:16];
    r = c[15:8];
    b = c[7:0];
    if (r == 8'd0 && g == 8'd0 && b == 8'd0) r = st;
    if (r > 8'd0 && r < mx && b == 8'd0)       r = r + st;
    else if (r >= mx && b < mx && g == 8'd0)   b = b + st;
    else if (b >= mx && r > 8'd0)              r = r - st;
    else if (b >= mx && g < mx)                g = g + st;
    else if (g >= mx && b > 8'd0)              b = b - st;
    else if (g >= mx && r < mx)                r = r + st;
    else if (r >= mx && g > 8'd0)              g = g - st;
    else begin
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
    end
    return {g, r, b};
  endfunction

  assign walk_next     = hue_step(walk, max_lvl, step_lvl);
  assign sts.walk_done = (widx == LW'(wsenc_pkg::LED_COUNT - 1));

  always_ff @(posedge clk) begin
    if (cmd.rb_load) walk <= rd_color;
    else if (cmd.rb_step) walk <= walk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) widx <= '0;
    else if (cmd.rb_load) widx <= '0;
    else if (cmd.rb_step) widx <= widx + LW'(1);
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      led  <= '0;
      bitn <= '0;
    end else if (cmd.frame_norm && pos_over) begin
      pos  <= '0;
      led  <= '0;
      bitn <= '0;
    end else if (cmd.out_load) begin
      if (pos_inc >= len) begin
        pos  <= '0;
        led  <= '0;
        bitn <= '0;
      end else begin
        pos <= pos_inc;
        if (bitn == wsenc_pkg::BIT_LAST) begin
          bitn <= '0;
          led  <= led + LW'(1);
        end else begin
          bitn <= bitn + BW'(1);
        end
      end
    end
  end

  // output register
  logic       cbit;
  logic [7:0] byte_val;

  assign cbit      = rd_color[wsenc_pkg::BIT_LAST - bitn];
  assign byte_val  = !in_data ? 8'd0 : (cbit ? one_pat : zero_pat);
  assign sts.out_block = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte   <= byte_val;
      frame_last <= (pos == len - PW'(1));
    end
  end

  `WSENC_ASSERT(a_bit_range, bitn <= wsenc_pkg::BIT_LAST, "bit counter past 23")
  `WSENC_ASSERT(a_one_writer, !(cmd.wr_item && cmd.rb_step), "two writers on color store")
  `WSENC_ASSERT(a_no_overwrite, !(cmd.out_load && out_valid && out_stall), "stalled beat overwritten")
  `WSENC_ASSERT_NEXT(a_pos_in_frame, cmd.out_load, pos < len, "frame position past end")

endmodule

### src/ws2812_spi_frame_encoder_rainbow.sv
// Top level: WS2812 SPI frame encoder with color store and rainbow walk.
// A color write is stored from idle; a byte request waits in the byte state until the
//   output register is free, then loads it; a rainbow step holds in_stall for the LED 0
//   read and the walk (one LED per cycle). No new byte is taken until the last is loaded.
// Reset (rst, synchronous): registers to defaults, all LEDs black via valid bits,
//   frame position to 0; no clearing pass, the block accepts beats right away.
module ws2812_spi_frame_encoder_rainbow (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [5:0]  led_sel,
  input  logic [23:0] color,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        frame_last
);

  // Controller sequences the three kinds of beat; the datapath holds the
  // color store, frame counters, hue walk and the output register.
  wsenc_pkg::cmd_t cmd;
  wsenc_pkg::sts_t sts;

  // One beat at a time: in_stall is high while a rainbow walk or a byte
  // request is in flight. A finished byte sits in the output register and
  // does not block new beats until another byte has to be loaded.
  wsenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Colors are stored decoded; the SPI pattern is chosen at output time,
  // so pattern registers may change between frames without touching state.
  wsenc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .led_sel    (led_sel),
    .color      (color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

endmodule
